### design/dmpb_pkg.sv
// Shared package for the depth min-pool backprojector.
// Holds field widths, register reset values, register indexes and the
// structs passed between the front, back and remainder units.
`default_nettype none

package dmpb_pkg;

  localparam int DIMW   = 14;   // clamped width/height, holds up to 16383
  localparam int WREGW  = 13;   // image_width / image_height register
  localparam int POOLW  = 5;
  localparam int INVW   = 24;
  localparam int CENW   = 16;
  localparam int ZW     = 16;
  localparam int PTW    = 33;
  localparam int FRACW  = 24;
  localparam int CIDXW  = 3;
  localparam int CDATAW = 24;
  localparam int QDEPTH = 2;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_MAX_POOL   = 16;

  localparam logic [WREGW-1:0] RST_WIDTH  = 13'd640;
  localparam logic [WREGW-1:0] RST_HEIGHT = 13'd480;
  localparam logic [POOLW-1:0] RST_POOL   = 5'd1;
  localparam logic [INVW-1:0]  RST_INV_FX = 24'd27962;
  localparam logic [INVW-1:0]  RST_INV_FY = 24'd27962;
  localparam logic [CENW-1:0]  RST_CX     = 16'd5120;
  localparam logic [CENW-1:0]  RST_CY     = 16'd3840;

  typedef enum logic [CIDXW-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_POOL,
    REG_INV_FX,
    REG_INV_FY,
    REG_CX,
    REG_CY
  } reg_idx_t;

  typedef struct packed {
    logic [DIMW-1:0]  w;
    logic [DIMW-1:0]  h;
    logic [POOLW-1:0] p;
    logic [POOLW-1:0] rem_w;   // w % p
    logic [POOLW-1:0] rem_h;   // (h-1) % p
  } geom_t;

  typedef struct packed {
    logic [INVW-1:0] inv_fx;
    logic [INVW-1:0] inv_fy;
    logic [CENW-1:0] cx;
    logic [CENW-1:0] cy;
  } cam_t;

  // Width of a signed block-centre coordinate (pixels)
  function automatic int coord_width(input int mw, input int mh);
    int cw;
    int rw;
    cw = $clog2(mw);
    rw = $clog2(mh);
    return ((cw > rw) ? cw : rw) + 7;
  endfunction

endpackage

`default_nettype wire

### design/dmpb_rem.sv
// Bit-serial remainder unit: w % p and (h-1) % p, one bit per cycle.
// Uses dmpb_pkg for widths.
`default_nettype none

module dmpb_rem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dmpb_pkg::DIMW-1:0]  num_a,
  input  logic [dmpb_pkg::DIMW-1:0]  num_b,
  input  logic [dmpb_pkg::POOLW-1:0] divisor,
  output logic                       busy,
  output logic [dmpb_pkg::POOLW-1:0] rem_a,
  output logic [dmpb_pkg::POOLW-1:0] rem_b
);
  import dmpb_pkg::*;

  localparam int CNTW = $clog2(DIMW + 1);

  logic [DIMW-1:0]  sh_a;
  logic [DIMW-1:0]  sh_b;
  logic [POOLW-1:0] dv;
  logic [CNTW-1:0]  cnt;

  function automatic logic [POOLW-1:0] rem_step(input logic [POOLW-1:0] r, input logic b,
                                                input logic [POOLW-1:0] d);
    logic [POOLW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[POOLW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      sh_a  <= num_a;
      sh_b  <= num_b;
      dv    <= divisor;
      rem_a <= '0;
      rem_b <= '0;
      cnt   <= CNTW'(DIMW);
      busy  <= 1'b1;
    end else if (busy) begin
      rem_a <= rem_step(rem_a, sh_a[DIMW-1], dv);
      rem_b <= rem_step(rem_b, sh_b[DIMW-1], dv);
      sh_a  <= sh_a << 1;
      sh_b  <= sh_b << 1;
      cnt   <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) busy <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### design/dmpb_queue.sv
// Small FIFO of jobs between the front and the back.
// Depth default from dmpb_pkg.
`default_nettype none

module dmpb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dmpb_pkg::QDEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    wr_ptr;
  logic [CNTW-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == CNTW'(DEPTH));
  assign dout  = slots[rd_ptr];

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
    return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (push && !pop)      count <= count + CNTW'(1);
      else if (pop && !push) count <= count - CNTW'(1);
    end
  end

endmodule

`default_nettype wire

### design/dmpb_front.sv
// Front end: raster counters, block-min column store (read-modify-write),
// block centre and emit decision. Pushes point jobs to the queue.
// Uses dmpb_pkg.
`default_nettype none

module dmpb_front #(
  parameter int MAX_WIDTH  = dmpb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dmpb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_POOL   = dmpb_pkg::DEF_MAX_POOL
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dmpb_pkg::geom_t         geom,
  input  logic                    rem_busy,
  input  logic                    q_full,
  input  logic                    depth_valid,
  output logic                    depth_stall,
  input  logic [dmpb_pkg::ZW-1:0] depth_mm,
  output logic                    push,
  output logic [2*dmpb_pkg::coord_width(MAX_WIDTH, MAX_HEIGHT)+dmpb_pkg::ZW-1:0] job,
  output logic                    clearing
);
  import dmpb_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int PW   = $clog2(MAX_POOL);
  localparam int UW   = coord_width(MAX_WIDTH, MAX_HEIGHT);
  localparam int CLRW = $clog2(MAX_WIDTH + 1);
  localparam int PCW  = ((PW > POOLW) ? PW : POOLW) + 1;

  typedef enum logic {F_IDLE, F_UPD} fstate_t;

  fstate_t          state;
  logic [CW-1:0]    col;
  logic [CW-1:0]    blk;
  logic [RW-1:0]    row;
  logic [PW-1:0]    cib;
  logic [PW-1:0]    rib;
  logic [CLRW-1:0]  clr_cnt;

  logic [ZW-1:0]    mem [MAX_WIDTH];
  logic [ZW-1:0]    rd_data;
  logic [CW-1:0]    slot;
  logic [ZW-1:0]    z_q;
  logic             emit_q;
  logic [UW-1:0]    u_q;
  logic [UW-1:0]    v_q;

  logic             accept;
  logic             row_end;
  logic             last_row;
  logic             cib_end;
  logic             rib_end;
  logic             emit_slot;
  logic [CW+POOLW-1:0] bp;
  logic [POOLW:0]   rh1;
  logic [UW-1:0]    u_calc;
  logic [UW-1:0]    v_calc;
  logic             upd;
  logic [ZW-1:0]    new_min;
  logic             mem_we;
  logic [CW-1:0]    mem_wa;
  logic [ZW-1:0]    mem_wd;

  assign clearing    = (clr_cnt < CLRW'(MAX_WIDTH));
  assign depth_stall = !(state == F_IDLE && !clearing && !rem_busy && !q_full);
  assign accept      = depth_valid && !depth_stall;

  // "at or beyond" ends, so a mid-frame geometry change still wraps
  assign row_end   = DIMW'(col) >= geom.w - DIMW'(1);
  assign last_row  = DIMW'(row) >= geom.h - DIMW'(1);
  assign cib_end   = PCW'(cib) >= PCW'(geom.p) - PCW'(1);
  assign rib_end   = PCW'(rib) >= PCW'(geom.p) - PCW'(1);
  assign emit_slot = (row_end || cib_end) && (last_row || rib_end);

  assign bp  = blk * geom.p;
  assign rh1 = {1'b0, geom.rem_h} + (POOLW+1)'(1);

  // block centre; the last block of a row and the last band are short
  assign u_calc = row_end ?
      UW'(geom.w) - UW'(1) - UW'(geom.rem_w >> 1) :
      UW'(bp) + UW'(geom.p >> 1);
  assign v_calc = last_row ?
      UW'(geom.h) - UW'(1) - UW'(rh1 >> 1) :
      UW'(row) - UW'(geom.p >> 1);

  assign upd     = (z_q != '0) && (rd_data == '0 || z_q < rd_data);
  assign new_min = upd ? z_q : rd_data;

  assign push = (state == F_UPD) && emit_q && (new_min != '0);
  assign job  = {u_q, v_q, new_min};

  assign mem_we = clearing || (state == F_UPD && (emit_q || upd));
  assign mem_wa = clearing ? clr_cnt[CW-1:0] : slot;
  assign mem_wd = (clearing || emit_q) ? '0 : z_q;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[blk];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      col     <= '0;
      blk     <= '0;
      row     <= '0;
      cib     <= '0;
      rib     <= '0;
      clr_cnt <= '0;
    end else begin
      if (clearing) clr_cnt <= clr_cnt + CLRW'(1);
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            state  <= F_UPD;
            slot   <= blk;
            z_q    <= depth_mm;
            emit_q <= emit_slot;
            u_q    <= u_calc;
            v_q    <= v_calc;
            if (row_end) begin
              col <= '0;
              cib <= '0;
              blk <= '0;
              if (last_row) begin
                row <= '0;
                rib <= '0;
              end else begin
                row <= row + RW'(1);
                rib <= rib_end ? '0 : rib + PW'(1);
              end
            end else begin
              col <= col + CW'(1);
              if (cib_end) begin
                cib <= '0;
                blk <= blk + CW'(1);
              end else begin
                cib <= cib + PW'(1);
              end
            end
          end
        end
        F_UPD: begin
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/dmpb_back.sv
// Back end: projects a queued block centre through the pinhole model.
// Two lanes (x, y), three multiply/sum steps, then an output register.
// Uses dmpb_pkg.
`default_nettype none

module dmpb_back #(
  parameter int MAX_WIDTH  = dmpb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dmpb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dmpb_pkg::cam_t           cam,
  input  logic                     q_empty,
  input  logic [2*dmpb_pkg::coord_width(MAX_WIDTH, MAX_HEIGHT)+dmpb_pkg::ZW-1:0] q_data,
  output logic                     pop,
  output logic                     point_valid,
  input  logic                     point_stall,
  output logic [dmpb_pkg::PTW-1:0] point_x,
  output logic [dmpb_pkg::PTW-1:0] point_y,
  output logic [dmpb_pkg::ZW-1:0]  point_z
);
  import dmpb_pkg::*;

  localparam int UW  = coord_width(MAX_WIDTH, MAX_HEIGHT);
  localparam int DW  = (((UW + 4) > 17) ? (UW + 4) : 17) + 1;
  localparam int P1W = DW + INVW;
  localparam int HIW = P1W - FRACW;
  localparam int SW  = P1W + ZW + 1;

  typedef enum logic [2:0] {B_IDLE, B_MUL1, B_MUL2, B_SUM, B_OUT} bstate_t;

  bstate_t state;

  logic [UW-1:0]        q_u;
  logic [UW-1:0]        q_v;
  logic [ZW-1:0]        q_z;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic                 take;

  logic [DW-1:0]        mag_x;
  logic [DW-1:0]        mag_y;
  logic                 neg_x;
  logic                 neg_y;
  logic [ZW-1:0]        z_q;
  logic [P1W-1:0]       p1x;
  logic [P1W-1:0]       p1y;
  logic [FRACW+ZW-1:0]  lo_x;
  logic [FRACW+ZW-1:0]  lo_y;
  logic [HIW+ZW-1:0]    hi_x;
  logic [HIW+ZW-1:0]    hi_y;

  assign {q_u, q_v, q_z} = q_data;

  assign dx = (DW'($signed(q_u)) <<< 4) - $signed(DW'(cam.cx));
  assign dy = (DW'($signed(q_v)) <<< 4) - $signed(DW'(cam.cy));

  assign take = !q_empty && (state == B_IDLE || (state == B_OUT && !point_stall));
  assign pop  = take;
  assign point_valid = (state == B_OUT);

  // recombine partial products, round half away from zero, reapply sign
  function automatic logic [PTW-1:0] finish(input logic [HIW+ZW-1:0] hi,
                                            input logic [FRACW+ZW-1:0] lo,
                                            input logic neg);
    logic [SW-1:0]  s;
    logic [PTW-1:0] m;
    s = (SW'(hi) << FRACW) + SW'(lo) + (SW'(1) << (FRACW - 1));
    m = s[FRACW +: PTW];
    return neg ? -m : m;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      if (take) begin
        mag_x <= dx[DW-1] ? DW'(-dx) : DW'(dx);
        mag_y <= dy[DW-1] ? DW'(-dy) : DW'(dy);
        neg_x <= dx[DW-1];
        neg_y <= dy[DW-1];
        z_q   <= q_z;
      end
      unique case (state)
        B_IDLE: begin
          if (take) state <= B_MUL1;
        end
        B_MUL1: begin
          p1x   <= mag_x * cam.inv_fx;
          p1y   <= mag_y * cam.inv_fy;
          state <= B_MUL2;
        end
        B_MUL2: begin
          lo_x  <= p1x[FRACW-1:0] * z_q;
          hi_x  <= p1x[P1W-1:FRACW] * z_q;
          lo_y  <= p1y[FRACW-1:0] * z_q;
          hi_y  <= p1y[P1W-1:FRACW] * z_q;
          state <= B_SUM;
        end
        B_SUM: begin
          point_x <= finish(hi_x, lo_x, neg_x);
          point_y <= finish(hi_y, lo_y, neg_y);
          point_z <= z_q;
          state   <= B_OUT;
        end
        B_OUT: begin
          if (!point_stall) state <= take ? B_MUL1 : B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/depth_min_pool_backprojector_core.sv
// An accepted pixel that closes a pool block reaches point_valid through the front's
// F_UPD state, the job queue and the back end's B_MUL1, B_MUL2, B_SUM and B_OUT states.
// The front takes no new pixel until the read-modify-write of the block-min store is done,
// and the back end takes a new job only when idle or as the current point leaves B_OUT.
// Reset: a pass over every block-min store slot zeroes it, input stalled meanwhile.
// Each config write reruns the remainder unit (a start, then 14 steps); input stalls meanwhile.
`default_nettype none

module depth_min_pool_backprojector_core #(
  parameter int MAX_WIDTH  = dmpb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dmpb_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_POOL   = dmpb_pkg::DEF_MAX_POOL
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         depth_valid,
  output logic                         depth_stall,
  input  logic [dmpb_pkg::ZW-1:0]      depth_mm,
  output logic                         point_valid,
  input  logic                         point_stall,
  output logic [dmpb_pkg::PTW-1:0]     point_x,
  output logic [dmpb_pkg::PTW-1:0]     point_y,
  output logic [dmpb_pkg::ZW-1:0]      point_z,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dmpb_pkg::CIDXW-1:0]   cfg_index,
  input  logic [dmpb_pkg::CDATAW-1:0]  cfg_data
);
  import dmpb_pkg::*;

  localparam int UW   = coord_width(MAX_WIDTH, MAX_HEIGHT);
  localparam int JW   = 2 * UW + ZW;
  localparam int PCMW = POOLW + 2;

  logic [WREGW-1:0] image_width;
  logic [WREGW-1:0] image_height;
  logic [POOLW-1:0] pool_side;
  logic [INVW-1:0]  inv_focal_x;
  logic [INVW-1:0]  inv_focal_y;
  logic [CENW-1:0]  center_x;
  logic [CENW-1:0]  center_y;
  logic             kick;
  logic             cfg_we;

  logic [DIMW-1:0]  w_c;
  logic [DIMW-1:0]  h_c;
  logic [POOLW-1:0] p_c;
  logic             rem_busy;
  logic [POOLW-1:0] rem_w;
  logic [POOLW-1:0] rem_h;
  geom_t            geom;
  cam_t             cam;

  logic             fe_push;
  logic [JW-1:0]    fe_job;
  logic             clearing;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [JW-1:0]    q_data;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // kick starts the remainder unit once the written value is in its register
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
      pool_side    <= RST_POOL;
      inv_focal_x  <= RST_INV_FX;
      inv_focal_y  <= RST_INV_FY;
      center_x     <= RST_CX;
      center_y     <= RST_CY;
      kick         <= 1'b1;
    end else begin
      kick <= cfg_we;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_WIDTH:  image_width  <= cfg_data[WREGW-1:0];
          REG_HEIGHT: image_height <= cfg_data[WREGW-1:0];
          REG_POOL:   pool_side    <= cfg_data[POOLW-1:0];
          REG_INV_FX: inv_focal_x  <= cfg_data[INVW-1:0];
          REG_INV_FY: inv_focal_y  <= cfg_data[INVW-1:0];
          REG_CX:     center_x     <= cfg_data[CENW-1:0];
          REG_CY:     center_y     <= cfg_data[CENW-1:0];
          default: ;
        endcase
      end
    end
  end

  // zero reads as one, oversize reads as the maximum
  assign w_c = (image_width == '0) ? DIMW'(1) :
               ({1'b0, image_width} > DIMW'(MAX_WIDTH)) ? DIMW'(MAX_WIDTH) :
               {1'b0, image_width};
  assign h_c = (image_height == '0) ? DIMW'(1) :
               ({1'b0, image_height} > DIMW'(MAX_HEIGHT)) ? DIMW'(MAX_HEIGHT) :
               {1'b0, image_height};
  assign p_c = (pool_side == '0) ? POOLW'(1) :
               (PCMW'(pool_side) > PCMW'(MAX_POOL)) ? POOLW'(MAX_POOL) :
               pool_side;

  dmpb_rem u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (kick),
    .num_a   (w_c),
    .num_b   (h_c - DIMW'(1)),
    .divisor (p_c),
    .busy    (rem_busy),
    .rem_a   (rem_w),
    .rem_b   (rem_h)
  );

  assign geom = '{w: w_c, h: h_c, p: p_c, rem_w: rem_w, rem_h: rem_h};
  assign cam  = '{inv_fx: inv_focal_x, inv_fy: inv_focal_y, cx: center_x, cy: center_y};

  dmpb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_POOL   (MAX_POOL)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .rem_busy    (rem_busy || kick),
    .q_full      (q_full),
    .depth_valid (depth_valid),
    .depth_stall (depth_stall),
    .depth_mm    (depth_mm),
    .push        (fe_push),
    .job         (fe_job),
    .clearing    (clearing)
  );

  dmpb_queue #(
    .WIDTH (JW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fe_push),
    .din   (fe_job),
    .pop   (q_pop),
    .dout  (q_data),
    .empty (q_empty),
    .full  (q_full)
  );

  dmpb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cam         (cam),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .pop         (q_pop),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z)
  );

  a_point_z_nonzero: assert property (@(posedge clk) disable iff (rst)
    point_valid |-> point_z != '0)
    else $error("point emitted with zero depth");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (clearing || rem_busy) |-> depth_stall)
    else $error("pixel input open during store clear or remainder update");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fe_push |-> !q_full)
    else $error("job pushed into full queue");

  a_pop_only_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

endmodule

`default_nettype wire
